[hdl/radix_code_gap_finder_top_defines.svh]
`ifndef RADIX_CODE_GAP_FINDER_TOP_DEFINES_SVH
`define RADIX_CODE_GAP_FINDER_TOP_DEFINES_SVH

// checked only outside reset
`define RCGF_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked during reset as well
`define RCGF_CHECK_RESET(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/rcgf_pkg.sv]
package rcgf_pkg;

  localparam int RADIX_W     = 6;
  localparam int LIMIT_W     = 48;
  localparam int OUT_W       = 49;
  localparam int COUNT_W     = 48;
  localparam int INDEX_W     = 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  localparam logic [INDEX_W-1:0] REG_RADIX     = 2'd0;
  localparam logic [INDEX_W-1:0] REG_GAP_MODE  = 2'd1;
  localparam logic [INDEX_W-1:0] REG_GAP_LIMIT = 2'd2;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] LETTER_BASE = 6'd10;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 48'd50;

  localparam logic MODE_PAIR      = 1'b0;
  localparam logic MODE_INTERVAL  = 1'b1;
  localparam logic GAP_MODE_RESET = MODE_INTERVAL;

  localparam logic [7:0] CHAR_NUL     = 8'h00;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_HYPHEN  = 8'h2D;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_BIT     = 8'h20;

  typedef enum logic [1:0] {
    OP_SKIP   = 2'd0,
    OP_STOP   = 2'd1,
    OP_DIGIT  = 2'd2,
    OP_REJECT = 2'd3
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [RADIX_W-1:0] digit;
    logic               finish;
  } token_t;

endpackage

[hdl/radix_code_gap_finder_top.sv]
// a line end passes the queue, exec line register, report hold and output registers
// throughput: one byte per cycle while sym_stall is low; the back end pops a byte when
// the queue is not empty and no line end waits on an untaken line; a four-word queue
// parts byte intake from the accumulate and report stages; synchronous active-high rst
// sets radix 10, gap mode 1, limit 50, clears line state, last value, queue, results
module radix_code_gap_finder_top #(
  parameter int VALUE_BITS = 48
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               sym_valid,
  output logic                               sym_stall,
  input  logic [7:0]                         symbol,
  input  logic                               end_line,
  output logic                               gap_valid,
  input  logic                               gap_stall,
  output logic signed [rcgf_pkg::OUT_W-1:0]  first_value,
  output logic signed [rcgf_pkg::OUT_W-1:0]  second_value,
  output logic [rcgf_pkg::COUNT_W-1:0]       gap_count,
  input  logic                               wr_en,
  input  logic [rcgf_pkg::INDEX_W-1:0]       wr_index,
  input  logic [rcgf_pkg::LIMIT_W-1:0]       wr_data
);
  import rcgf_pkg::*;

  logic [RADIX_W-1:0]        radix;
  logic                      gap_mode;
  logic [LIMIT_W-1:0]        gap_limit;
  token_t                    token_in;
  token_t                    token_out;
  logic                      push;
  logic                      pop;
  logic                      queue_empty;
  logic                      queue_full;
  logic                      line_take;
  logic                      line_valid;
  logic signed [VALUE_BITS:0] line_value;
  logic signed [VALUE_BITS:0] line_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix     <= RADIX_RESET;
      gap_mode  <= GAP_MODE_RESET;
      gap_limit <= LIMIT_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_RADIX: begin
          radix <= wr_data[RADIX_W-1:0];
        end
        REG_GAP_MODE: begin
          gap_mode <= wr_data[0];
        end
        REG_GAP_LIMIT: begin
          gap_limit <= wr_data;
        end
        default: begin
        end
      endcase
    end
  end

  rcgf_front u_front (
    .sym_valid  (sym_valid),
    .symbol     (symbol),
    .end_line   (end_line),
    .queue_full (queue_full),
    .sym_stall  (sym_stall),
    .push       (push),
    .token      (token_in)
  );

  rcgf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .token_in  (token_in),
    .pop       (pop),
    .token_out (token_out),
    .empty     (queue_empty),
    .full      (queue_full)
  );

  rcgf_exec #(
    .VALUE_BITS (VALUE_BITS)
  ) u_exec (
    .clk         (clk),
    .rst         (rst),
    .token       (token_out),
    .queue_empty (queue_empty),
    .radix       (radix),
    .line_take   (line_take),
    .pop         (pop),
    .line_valid  (line_valid),
    .line_value  (line_value),
    .line_last   (line_last)
  );

  rcgf_report #(
    .VALUE_BITS (VALUE_BITS)
  ) u_report (
    .clk          (clk),
    .rst          (rst),
    .line_valid   (line_valid),
    .line_value   (line_value),
    .line_last    (line_last),
    .gap_mode     (gap_mode),
    .gap_limit    (gap_limit),
    .gap_stall    (gap_stall),
    .line_take    (line_take),
    .gap_valid    (gap_valid),
    .first_value  (first_value),
    .second_value (second_value),
    .gap_count    (gap_count)
  );

endmodule

[hdl/rcgf_front.sv]
module rcgf_front (
  input  logic            sym_valid,
  input  logic [7:0]      symbol,
  input  logic            end_line,
  input  logic            queue_full,
  output logic            sym_stall,
  output logic            push,
  output rcgf_pkg::token_t token
);
  import rcgf_pkg::*;

  logic [7:0] upper;

  assign sym_stall = queue_full;
  assign push      = sym_valid && !queue_full;

  always_comb begin
    upper        = symbol;
    token.op     = OP_REJECT;
    token.digit  = '0;
    token.finish = end_line;
    if (symbol >= CHAR_LOWER_A && symbol <= CHAR_LOWER_Z) begin
      upper = symbol - CASE_BIT;
    end
    if (symbol == CHAR_NEWLINE) begin
      token.op     = OP_SKIP;
      token.finish = 1'b1;
    end else if (symbol == CHAR_NUL) begin
      token.op = OP_STOP;
    end else if (upper == CHAR_HYPHEN) begin
      token.op = OP_SKIP;
    end else if (upper >= CHAR_ZERO && upper <= CHAR_NINE) begin
      token.op    = OP_DIGIT;
      token.digit = RADIX_W'(upper - CHAR_ZERO);
    end else if (upper >= CHAR_UPPER_A && upper <= CHAR_UPPER_Z) begin
      token.op    = OP_DIGIT;
      token.digit = RADIX_W'(upper - CHAR_UPPER_A) + LETTER_BASE;
    end
  end

endmodule

[hdl/rcgf_queue.sv]
module rcgf_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  rcgf_pkg::token_t token_in,
  input  logic             pop,
  output rcgf_pkg::token_t token_out,
  output logic             empty,
  output logic             full
);
  import rcgf_pkg::*;

  token_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10: begin
          fill <= fill + 1'b1;
        end
        2'b01: begin
          fill <= fill - 1'b1;
        end
        default: begin
          fill <= fill;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= token_in;
    end
  end

  assign token_out = slots[rd_ptr];
  assign empty     = (fill == '0);
  assign full      = (fill == (QPTR_W+1)'(QUEUE_DEPTH));

endmodule

[hdl/rcgf_exec.sv]
module rcgf_exec #(
  parameter int VALUE_BITS = 48
) (
  input  logic                              clk,
  input  logic                              rst,
  input  rcgf_pkg::token_t                  token,
  input  logic                              queue_empty,
  input  logic [rcgf_pkg::RADIX_W-1:0]      radix,
  input  logic                              line_take,
  output logic                              pop,
  output logic                              line_valid,
  output logic signed [VALUE_BITS:0]        line_value,
  output logic signed [VALUE_BITS:0]        line_last
);
  import rcgf_pkg::*;

  localparam int VW = VALUE_BITS + 1;
  localparam int PW = VALUE_BITS + RADIX_W + 1;

  logic [VALUE_BITS-1:0]  accumulator;
  logic [VALUE_BITS-1:0]  accumulator_next;
  logic                   too_large;
  logic                   too_large_next;
  logic                   bad_digit;
  logic                   bad_digit_next;
  logic                   line_rejected;
  logic                   line_rejected_next;
  logic                   text_stopped;
  logic                   text_stopped_next;
  logic signed [VW-1:0]   last_value;
  logic signed [VW-1:0]   value;
  logic [PW-1:0]          product;
  logic                   radix_ok;

  assign radix_ok = (radix >= RADIX_MIN) && (radix <= RADIX_MAX);
  assign product  = PW'(accumulator) * PW'(radix) + PW'(token.digit);
  assign pop      = !queue_empty && (!token.finish || !line_valid || line_take);

  always_comb begin
    accumulator_next   = accumulator;
    too_large_next     = too_large;
    bad_digit_next     = bad_digit;
    line_rejected_next = line_rejected;
    text_stopped_next  = text_stopped;
    if (!line_rejected && !text_stopped) begin
      case (token.op)
        OP_STOP: begin
          text_stopped_next = 1'b1;
        end
        OP_REJECT: begin
          line_rejected_next = 1'b1;
        end
        OP_DIGIT: begin
          if (!radix_ok || token.digit >= radix) begin
            bad_digit_next = 1'b1;
          end else if (!too_large && !bad_digit) begin
            if (product[PW-1:VALUE_BITS] != '0) begin
              too_large_next = 1'b1;
            end else begin
              accumulator_next = product[VALUE_BITS-1:0];
            end
          end
        end
        default: begin
        end
      endcase
    end
    if (!radix_ok || bad_digit_next || too_large_next) begin
      value = {VW{1'b1}};
    end else begin
      value = signed'({1'b0, accumulator_next});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator   <= '0;
      too_large     <= 1'b0;
      bad_digit     <= 1'b0;
      line_rejected <= 1'b0;
      text_stopped  <= 1'b0;
      last_value    <= '0;
      line_valid    <= 1'b0;
    end else begin
      if (pop && token.finish && !line_rejected_next) begin
        line_valid <= 1'b1;
      end else if (line_take) begin
        line_valid <= 1'b0;
      end
      if (pop) begin
        if (token.finish) begin
          accumulator   <= '0;
          too_large     <= 1'b0;
          bad_digit     <= 1'b0;
          line_rejected <= 1'b0;
          text_stopped  <= 1'b0;
          if (!line_rejected_next) begin
            last_value <= value;
            line_value <= value;
            line_last  <= last_value;
          end
        end else begin
          accumulator   <= accumulator_next;
          too_large     <= too_large_next;
          bad_digit     <= bad_digit_next;
          line_rejected <= line_rejected_next;
          text_stopped  <= text_stopped_next;
        end
      end
    end
  end

endmodule

[hdl/rcgf_report.sv]
module rcgf_report #(
  parameter int VALUE_BITS = 48
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               line_valid,
  input  logic signed [VALUE_BITS:0]         line_value,
  input  logic signed [VALUE_BITS:0]         line_last,
  input  logic                               gap_mode,
  input  logic [rcgf_pkg::LIMIT_W-1:0]       gap_limit,
  input  logic                               gap_stall,
  output logic                               line_take,
  output logic                               gap_valid,
  output logic signed [rcgf_pkg::OUT_W-1:0]  first_value,
  output logic signed [rcgf_pkg::OUT_W-1:0]  second_value,
  output logic [rcgf_pkg::COUNT_W-1:0]       gap_count
);
  import rcgf_pkg::*;

  localparam int VW = VALUE_BITS + 1;
  localparam int DW = VALUE_BITS + 2;
  localparam int RW = ((DW > OUT_W) ? DW : OUT_W) + 1;
  localparam logic signed [RW-1:0] ONE_W = RW'(1);

  logic signed [DW-1:0] line_diff;
  logic                 line_gap;
  logic                 held_valid;
  logic signed [VW-1:0] held_value;
  logic signed [VW-1:0] held_last;
  logic signed [DW-1:0] held_count;
  logic                 out_free;
  logic                 held_free;
  logic signed [RW-1:0] last_w;
  logic signed [RW-1:0] value_w;
  logic signed [RW-1:0] count_w;
  logic signed [RW-1:0] limit_w;
  logic signed [RW-1:0] first_w;
  logic signed [RW-1:0] second_w;
  logic signed [RW-1:0] cnt_w;
  logic                 fits;

  // value - last - 1
  assign line_diff = DW'(line_value) + ~DW'(line_last);
  assign line_gap  = !line_diff[DW-1] && (line_diff != '0);

  assign out_free  = !gap_valid || !gap_stall;
  assign held_free = !held_valid || out_free;
  assign line_take = line_valid && (!line_gap || held_free);

  always_comb begin
    last_w  = RW'(held_last);
    value_w = RW'(held_value);
    count_w = RW'(held_count);
    limit_w = RW'({1'b0, gap_limit});
    fits    = (count_w <= limit_w);
    if (gap_mode == MODE_PAIR) begin
      first_w  = last_w;
      second_w = value_w;
      cnt_w    = count_w;
    end else begin
      first_w  = last_w + ONE_W;
      second_w = fits ? (value_w - ONE_W) : (last_w + limit_w);
      cnt_w    = fits ? count_w : limit_w;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      gap_valid  <= 1'b0;
    end else begin
      if (held_free) begin
        held_valid <= line_valid && line_gap;
      end
      if (out_free) begin
        gap_valid <= held_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (line_valid && line_gap && held_free) begin
      held_value <= line_value;
      held_last  <= line_last;
      held_count <= line_diff;
    end
    if (held_valid && out_free) begin
      first_value  <= first_w[OUT_W-1:0];
      second_value <= second_w[OUT_W-1:0];
      gap_count    <= cnt_w[COUNT_W-1:0];
    end
  end

endmodule

[hdl/rcgf_checker.sv]
`include "radix_code_gap_finder_top_defines.svh"

module rcgf_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               sym_valid,
  input logic                               sym_stall,
  input logic [7:0]                         symbol,
  input logic                               end_line,
  input logic                               gap_valid,
  input logic                               gap_stall,
  input logic signed [rcgf_pkg::OUT_W-1:0]  first_value,
  input logic signed [rcgf_pkg::OUT_W-1:0]  second_value,
  input logic [rcgf_pkg::COUNT_W-1:0]       gap_count,
  input logic                               wr_en,
  input logic [rcgf_pkg::INDEX_W-1:0]       wr_index,
  input logic [rcgf_pkg::LIMIT_W-1:0]       wr_data
);

  `RCGF_CHECK_RESET(a_reset_empties, rst |=> !gap_valid && !sym_stall, "reset left data in flight")

  `RCGF_CHECK(a_word_held, gap_valid && gap_stall |=> gap_valid && $stable(first_value) && $stable(second_value) && $stable(gap_count), "stalled gap word changed")

  // pair mode counts between the values, interval mode counts the interval itself
  `RCGF_CHECK(a_count_matches, gap_valid |-> gap_count == second_value[47:0] - first_value[47:0] - 48'd1 || gap_count == second_value[47:0] - first_value[47:0] + 48'd1, "gap count disagrees with its bounds")

endmodule

bind radix_code_gap_finder_top rcgf_checker u_checker (.*);

[bench/rcgf_gap_checker.sv]
module rcgf_gap_checker import rcgf_pkg::*; #(
  parameter int VALUE_BITS = 48
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      sym_valid,
  input  logic                      sym_stall,
  input  logic [7:0]                symbol,
  input  logic                      end_line,
  input  logic                      gap_valid,
  input  logic                      gap_stall,
  input  logic signed [OUT_W-1:0]   first_value,
  input  logic signed [OUT_W-1:0]   second_value,
  input  logic [COUNT_W-1:0]        gap_count,
  input  logic                      wr_en,
  input  logic [INDEX_W-1:0]        wr_index,
  input  logic [LIMIT_W-1:0]        wr_data,
  output int unsigned               fail_count,
  output int unsigned               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [OUT_W-1:0]   first;
    logic [OUT_W-1:0]   second;
    logic [COUNT_W-1:0] count;
  } gap_word_t;

  localparam longint unsigned CODE_MAX = (64'd1 << VALUE_BITS) - 64'd1;

  logic [RADIX_W-1:0] base;
  logic               mode;
  logic [LIMIT_W-1:0] limit;

  longint unsigned acc;
  bit              overflowed;
  bit              bad_digit;
  bit              rejected;
  bit              stopped;
  longint          last_code;

  gap_word_t   gaps_due[$];
  gap_word_t   want;
  int unsigned mismatches = 0;

  function automatic bit base_ok();
    return base >= RADIX_MIN && base <= RADIX_MAX;
  endfunction

  function automatic void clear_line();
    acc = 0;
    overflowed = 0;
    bad_digit = 0;
    rejected = 0;
    stopped = 0;
  endfunction

  function automatic void take_symbol(input logic [7:0] b);
    logic [7:0]      c;
    longint unsigned d;
    if (rejected || stopped) return;
    if (b == CHAR_NUL) begin
      stopped = 1;
      return;
    end
    c = b;
    if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) c = c - CASE_BIT;
    if (c == CHAR_HYPHEN) return;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      d = 64'(c - CHAR_ZERO);
    end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      d = 64'(c - CHAR_UPPER_A);
      d = d + LETTER_BASE;
    end else begin
      rejected = 1;
      return;
    end
    if (!base_ok() || d >= base) begin
      bad_digit = 1;
      return;
    end
    if (overflowed || bad_digit) return;
    if (acc > (CODE_MAX - d) / base) begin
      overflowed = 1;
      return;
    end
    acc = acc * base + d;
  endfunction

  function automatic void close_line();
    longint    code;
    longint    lo;
    longint    hi;
    longint    cnt;
    longint    lim_s;
    gap_word_t w;
    if (!rejected) begin
      if (!base_ok() || bad_digit || overflowed) code = -1;
      else code = longint'(acc);
      if (code > last_code + 1) begin
        cnt = code - last_code - 1;
        lim_s = longint'({16'd0, limit});
        if (mode == MODE_PAIR) begin
          lo = last_code;
          hi = code;
        end else begin
          lo = last_code + 1;
          if (cnt <= lim_s) begin
            hi = code - 1;
          end else begin
            hi = last_code + lim_s;
            cnt = lim_s;
          end
        end
        w.first = lo[OUT_W-1:0];
        w.second = hi[OUT_W-1:0];
        w.count = cnt[COUNT_W-1:0];
        gaps_due.push_back(w);
      end
      last_code = code;
    end
    clear_line();
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      base = RADIX_RESET;
      mode = GAP_MODE_RESET;
      limit = LIMIT_RESET;
      clear_line();
      last_code = 0;
      gaps_due.delete();
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_RADIX: base = wr_data[RADIX_W-1:0];
          REG_GAP_MODE: mode = wr_data[0];
          REG_GAP_LIMIT: limit = wr_data;
          default: ;
        endcase
      end
      if (sym_valid && !sym_stall) begin
        if (symbol == CHAR_NEWLINE) begin
          close_line();
        end else begin
          take_symbol(symbol);
          if (end_line) close_line();
        end
      end
      if (gap_valid && !gap_stall) begin
        if (gaps_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected gap word: first %0d second %0d count %0d",
                     first_value, second_value, gap_count);
        end else begin
          want = gaps_due.pop_front();
          if (first_value !== want.first || second_value !== want.second ||
              gap_count !== want.count) begin
            mismatches++;
            if (mismatches <= 10)
              $display("gap word mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                       $signed(want.first), $signed(want.second), want.count,
                       first_value, second_value, gap_count);
          end
        end
      end
    end
    fail_count <= mismatches;
    pending <= gaps_due.size();
  end

endmodule

[bench/radix_code_gap_finder_top_tb.sv]
module radix_code_gap_finder_top_tb import rcgf_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int              CODE_BITS   = 48;
  localparam longint unsigned CODE_MAX    = (64'd1 << CODE_BITS) - 64'd1;
  localparam int              HOLD_CYCLES = 300;
  localparam int              PHASES      = 6;
  localparam int              PHASE_BYTES = 58;

  typedef enum int {LINE_OPEN, LINE_NEWLINE, LINE_FLAG} line_end_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      sym_valid = 1'b0;
  logic                      sym_stall;
  logic [7:0]                symbol = '0;
  logic                      end_line = 1'b0;
  logic                      gap_valid;
  logic                      gap_stall = 1'b0;
  logic signed [OUT_W-1:0]   first_value;
  logic signed [OUT_W-1:0]   second_value;
  logic [COUNT_W-1:0]        gap_count;
  logic                      wr_en = 1'b0;
  logic [INDEX_W-1:0]        wr_index = '0;
  logic [LIMIT_W-1:0]        wr_data = '0;

  int unsigned fail_count;
  int unsigned pending;

  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  logic [7:0]         line_buf[$];
  logic [RADIX_W-1:0] cur_base;
  logic [LIMIT_W-1:0] cur_limit;
  logic               cur_mode;
  longint unsigned    cursor;
  longint unsigned    v;
  int unsigned        sent;
  int unsigned        roll;
  int unsigned        pick;
  int unsigned        noise_len;
  logic [7:0]         noise_byte;

  radix_code_gap_finder_top #(.VALUE_BITS(CODE_BITS)) dut (
    .clk(clk), .rst(rst),
    .sym_valid(sym_valid), .sym_stall(sym_stall),
    .symbol(symbol), .end_line(end_line),
    .gap_valid(gap_valid), .gap_stall(gap_stall),
    .first_value(first_value), .second_value(second_value), .gap_count(gap_count),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  rcgf_gap_checker #(.VALUE_BITS(CODE_BITS)) gap_check (
    .clk(clk), .rst(rst),
    .sym_valid(sym_valid), .sym_stall(sym_stall),
    .symbol(symbol), .end_line(end_line),
    .gap_valid(gap_valid), .gap_stall(gap_stall),
    .first_value(first_value), .second_value(second_value), .gap_count(gap_count),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .fail_count(fail_count), .pending(pending)
  );

  always #1 clk = ~clk;

  initial begin
    #1ms;
    $display("simulation failed");
    $finish;
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    wait (!rst);
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        gap_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      gap_stall <= !quiet && ($urandom_range(99) < 9);
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic eol);
    while (!quiet && $urandom_range(99) < 9) begin
      sym_valid <= 1'b0;
      @(posedge clk);
    end
    sym_valid <= 1'b1;
    symbol <= b;
    end_line <= eol;
    @(posedge clk);
    while (sym_stall) @(posedge clk);
  endtask

  task automatic send_buf(input line_end_t ending);
    for (int i = 0; i < line_buf.size(); i++)
      push_byte(line_buf[i], ending == LINE_FLAG && i == line_buf.size() - 1);
    if (ending == LINE_NEWLINE || (ending == LINE_FLAG && line_buf.size() == 0))
      push_byte(CHAR_NEWLINE, ending == LINE_FLAG);
  endtask

  task automatic send_text(input string text, input line_end_t ending);
    line_buf.delete();
    for (int i = 0; i < text.len(); i++) line_buf.push_back(text[i]);
    send_buf(ending);
  endtask

  // digits of a code in the given base, mixed case, with stray hyphens
  function automatic void render_code(input longint unsigned val, input int unsigned b);
    longint unsigned rest;
    logic [7:0]      ch;
    int unsigned     d;
    line_buf.delete();
    rest = val;
    do begin
      d = 32'(rest % b);
      rest = rest / b;
      if (d < 10) ch = 8'(CHAR_ZERO + d);
      else ch = 8'(CHAR_UPPER_A + (d - 10));
      if (d >= 10 && $urandom_range(1)) ch = ch | CASE_BIT;
      line_buf.push_front(ch);
      if ($urandom_range(7) == 0) line_buf.push_front(CHAR_HYPHEN);
    end while (rest != 0);
    if ($urandom_range(5) == 0)
      repeat ($urandom_range(1, 3)) line_buf.push_front(CHAR_ZERO);
  endfunction

  task automatic settle();
    sym_valid <= 1'b0;
    repeat (2) @(posedge clk);
    wait (pending == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_config(input logic [RADIX_W-1:0] r, input logic m,
                            input logic [LIMIT_W-1:0] lim);
    wr_en <= 1'b1;
    wr_index <= REG_RADIX;
    wr_data <= LIMIT_W'(r);
    @(posedge clk);
    wr_index <= REG_GAP_MODE;
    wr_data <= LIMIT_W'(m);
    @(posedge clk);
    wr_index <= REG_GAP_LIMIT;
    wr_data <= lim;
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset settings: radix 10, interval mode, limit 50
    send_text("5", LINE_NEWLINE);
    send_text("6", LINE_NEWLINE);
    send_text("a-b", LINE_NEWLINE);
    send_text("", LINE_NEWLINE);
    send_text("--", LINE_NEWLINE);
    send_text("100", LINE_NEWLINE);
    send_text("1x0!", LINE_NEWLINE);
    // zero byte stops the token, later junk is skipped
    send_text("200", LINE_OPEN);
    push_byte(CHAR_NUL, 1'b0);
    send_text("!9", LINE_NEWLINE);
    send_text("281474976710655", LINE_NEWLINE);
    send_text("281474976710656", LINE_NEWLINE);
    send_text("7", LINE_FLAG);
    send_text("", LINE_FLAG);

    settle();
    set_config(RADIX_MAX, MODE_PAIR, '1);
    send_text("zz", LINE_NEWLINE);
    send_text("Zz-1", LINE_FLAG);
    send_text("ZZZZZZZZZZ", LINE_NEWLINE);
    send_text("3", LINE_NEWLINE);

    settle();
    set_config(RADIX_MIN, MODE_INTERVAL, '0);
    send_text("1111", LINE_NEWLINE);
    send_text("12", LINE_NEWLINE);
    send_text("11111", LINE_NEWLINE);

    // bases outside 2..36 make every code invalid
    settle();
    set_config(6'd1, MODE_PAIR, LIMIT_RESET);
    send_text("0", LINE_NEWLINE);
    send_text("1", LINE_NEWLINE);
    settle();
    set_config(6'd63, MODE_INTERVAL, LIMIT_RESET);
    send_text("5", LINE_NEWLINE);

    cursor = 0;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: cur_base = RADIX_MIN;
        1: cur_base = RADIX_MAX;
        2: cur_base = RADIX_RESET;
        default: cur_base = RADIX_W'($urandom_range(RADIX_MAX, RADIX_MIN));
      endcase
      cur_mode = (p < 2) ? p[0] : 1'($urandom_range(1));
      if (p == 3) cur_limit = '1;
      else if (p == 4) cur_limit = LIMIT_W'({$urandom, $urandom});
      else if (p == 5) cur_limit = '0;
      else cur_limit = LIMIT_W'($urandom_range(40));
      settle();
      set_config(cur_base, cur_mode, cur_limit);
      if (p == 1) hold_req = 1'b1;
      quiet = (p == 2);
      sent = 0;
      while (sent < PHASE_BYTES) begin
        roll = $urandom_range(99);
        if (roll < 12) begin
          noise_len = $urandom_range(1, 12);
          repeat (noise_len) begin
            noise_byte = 8'($urandom_range(255));
            push_byte(noise_byte, $urandom_range(7) == 0);
          end
          push_byte(CHAR_NEWLINE, 1'b0);
        end else begin
          pick = $urandom_range(99);
          if (pick < 15) v = cursor + $urandom_range(1);
          else if (pick < 70) v = cursor + $urandom_range(2, 30);
          else if (pick < 80) v = 64'($urandom_range(1000));
          else if (pick < 88) v = cursor + ({$urandom, $urandom} & CODE_MAX);
          else if (pick < 93) v = CODE_MAX + 1 - $urandom_range(4);
          else v = cursor + cur_limit + $urandom_range(2);
          render_code(v, 32'(cur_base));
          if (roll < 20) begin
            noise_byte = 8'($urandom_range(255));
            if (noise_byte == CHAR_NEWLINE) noise_byte = CHAR_NUL;
            line_buf[$urandom_range(line_buf.size() - 1)] = noise_byte;
          end else begin
            sent += line_buf.size();
            cursor = (v > CODE_MAX) ? 0 : v;
          end
          send_buf(($urandom_range(4) == 0) ? LINE_FLAG : LINE_NEWLINE);
        end
      end
    end
    quiet = 1'b0;

    settle();
    if (fail_count == 0 && pending == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/rcgf_pkg.sv
hdl/rcgf_front.sv
hdl/rcgf_queue.sv
hdl/rcgf_exec.sv
hdl/rcgf_report.sv
hdl/radix_code_gap_finder_top.sv
hdl/rcgf_checker.sv
bench/rcgf_gap_checker.sv
bench/radix_code_gap_finder_top_tb.sv
